>>> sv/vnorm_pkg.sv
// shared types and constants for the 3d vector normalize pipeline
package vnorm_pkg;

   // number of vector components handled side by side
   localparam int LaneCount = 3;

   // integer bits of the signed unit format (sign plus one)
   localparam int UnitIntBits = 2;

   // sign of each input component, carried along with the magnitudes
   typedef struct packed {
      logic neg_z;
      logic neg_y;
      logic neg_x;
   } sign_type;

endpackage

>>> sv/vnorm_sumsq.sv
// front end: component magnitudes, squares and sum of squares over three stages
module vnorm_sumsq #(
   parameter int CW = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  logic signed [CW-1:0]                 in_comp_x,
   input  logic signed [CW-1:0]                 in_comp_y,
   input  logic signed [CW-1:0]                 in_comp_z,
   output logic                                 out_valid,
   output logic [2*CW-1:0]                      out_sum,
   output logic [vnorm_pkg::LaneCount-1:0][CW-1:0] out_mag,
   output vnorm_pkg::sign_type                  out_sign
);
   import vnorm_pkg::*;

   localparam int SW = 2 * CW;

   logic [LaneCount-1:0][CW-1:0] comp;
   logic [LaneCount-1:0]         neg;
   logic [LaneCount-1:0][CW-1:0] mag_in;
   logic [LaneCount-1:0][SW-1:0] sq_in;
   logic [SW-1:0]                sum_in;
   sign_type                     sign_in;

   logic [2:0]                   valid_ff;
   logic [LaneCount-1:0][CW-1:0] mag1_ff;
   logic [LaneCount-1:0][CW-1:0] mag2_ff;
   logic [LaneCount-1:0][CW-1:0] mag3_ff;
   sign_type                     sign1_ff;
   sign_type                     sign2_ff;
   sign_type                     sign3_ff;
   logic [LaneCount-1:0][SW-1:0] sq_ff;
   logic [SW-1:0]                sum_ff;

   // stage 1 logic: split each component into sign and magnitude
   always_comb begin
      comp[0] = in_comp_x;
      comp[1] = in_comp_y;
      comp[2] = in_comp_z;
      for (int l = 0; l < LaneCount; l++) begin
         neg[l]    = comp[l][CW-1];
         mag_in[l] = neg[l] ? (~comp[l] + CW'(1)) : comp[l];
      end
      sign_in.neg_x = neg[0];
      sign_in.neg_y = neg[1];
      sign_in.neg_z = neg[2];
   end

   // stage 2 logic: one square per lane
   always_comb begin
      for (int l = 0; l < LaneCount; l++) begin
         sq_in[l] = SW'(mag1_ff[l]) * SW'(mag1_ff[l]);
      end
   end

   // stage 3 logic: the sum of three squares stays below 2^(2*CW)
   assign sum_in = sq_ff[0] + sq_ff[1] + sq_ff[2];

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mag1_ff  <= mag_in;
      sign1_ff <= sign_in;
      sq_ff    <= sq_in;
      mag2_ff  <= mag1_ff;
      sign2_ff <= sign1_ff;
      sum_ff   <= sum_in;
      mag3_ff  <= mag2_ff;
      sign3_ff <= sign2_ff;
   end

   assign out_valid = valid_ff[2];
   assign out_sum   = sum_ff;
   assign out_mag   = mag3_ff;
   assign out_sign  = sign3_ff;

endmodule

>>> sv/vnorm_sqrt.sv
// pipelined digit-by-digit integer square root, one result bit per stage
module vnorm_sqrt #(
   parameter int CW     = 16,
   parameter int SIDE_W = 51
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [2*CW-1:0]   in_sum,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [CW-1:0]     out_root,
   output logic [SIDE_W-1:0] out_side
);

   localparam int SW = 2 * CW;

   logic [SW-1:0]     rem_src   [0:CW-1];
   logic [CW-1:0]     root_src  [0:CW-1];
   logic [SIDE_W-1:0] side_src  [0:CW-1];
   logic [SW-1:0]     trial     [0:CW-1];
   logic [SW-1:0]     rem_in    [0:CW-1];
   logic [CW-1:0]     root_in   [0:CW-1];

   logic [CW-1:0]     valid_ff;
   logic [SW-1:0]     rem_ff    [0:CW-1];
   logic [CW-1:0]     root_ff   [0:CW-1];
   logic [SIDE_W-1:0] side_ff   [0:CW-1];

   // stage inputs: first stage from the ports, the rest from the stage before
   always_comb begin
      rem_src[0]  = in_sum;
      root_src[0] = '0;
      side_src[0] = in_side;
      for (int s = 1; s < CW; s++) begin
         rem_src[s]  = rem_ff[s-1];
         root_src[s] = root_ff[s-1];
         side_src[s] = side_ff[s-1];
      end
   end

   // stage s decides root bit CW-1-s; remainder holds sum minus root squared
   // adding that bit grows the square by root*2^(bit+1) + 2^(2*bit), disjoint bits
   always_comb begin
      for (int s = 0; s < CW; s++) begin
         trial[s] = (SW'(root_src[s]) << (CW - s)) | (SW'(1) << (2 * (CW - 1 - s)));
         if (rem_src[s] >= trial[s]) begin
            rem_in[s]  = rem_src[s] - trial[s];
            root_in[s] = root_src[s] | (CW'(1) << (CW - 1 - s));
         end else begin
            rem_in[s]  = rem_src[s];
            root_in[s] = root_src[s];
         end
      end
   end

   // valid bits travel with the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[CW-2:0], in_valid};
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      for (int s = 0; s < CW; s++) begin
         rem_ff[s]  <= rem_in[s];
         root_ff[s] <= root_in[s];
         side_ff[s] <= side_src[s];
      end
   end

   assign out_valid = valid_ff[CW-1];
   assign out_root  = root_ff[CW-1];
   assign out_side  = side_ff[CW-1];

endmodule

>>> sv/vnorm_div.sv
// three-lane pipelined restoring divider with sign, saturation and zero handling
module vnorm_div #(
   parameter int CW = 16,
   parameter int UF = 14
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   input  logic [CW-1:0]                           in_len,
   input  logic [vnorm_pkg::LaneCount-1:0][CW-1:0] in_mag,
   input  vnorm_pkg::sign_type                     in_sign,
   output logic                                    out_valid,
   output logic [vnorm_pkg::LaneCount-1:0][UF+vnorm_pkg::UnitIntBits-1:0] out_unit,
   output logic [CW-1:0]                           out_len,
   output logic                                    out_zero
);
   import vnorm_pkg::*;

   localparam int NQ = UF + 1;
   localparam int RW = CW + 1;
   localparam int UW = UF + UnitIntBits;
   localparam logic [NQ-1:0] UnitOne = {1'b1, {UF{1'b0}}};

   logic [RW-1:0]  part     [0:NQ-1][0:LaneCount-1];
   logic [RW-1:0]  diff     [0:NQ-1][0:LaneCount-1];
   logic [NQ-1:0]  quo_src  [0:NQ-1][0:LaneCount-1];
   logic [CW-1:0]  rem_in   [0:NQ-1][0:LaneCount-1];
   logic [NQ-1:0]  quo_in   [0:NQ-1][0:LaneCount-1];
   logic [CW-1:0]  len_src  [0:NQ-1];
   sign_type       sign_src [0:NQ-1];

   logic [NQ-1:0]  valid_ff;
   logic [CW-1:0]  rem_ff   [0:NQ-1][0:LaneCount-1];
   logic [NQ-1:0]  quo_ff   [0:NQ-1][0:LaneCount-1];
   logic [CW-1:0]  len_ff   [0:NQ-1];
   sign_type       sign_ff  [0:NQ-1];

   logic [LaneCount-1:0]         neg_last;
   logic                         zero_in;
   logic [NQ-1:0]                quo_sat  [0:LaneCount-1];
   logic [UW-1:0]                mag_last [0:LaneCount-1];
   logic [LaneCount-1:0][UW-1:0] unit_in;

   logic                         out_valid_ff;
   logic [LaneCount-1:0][UW-1:0] unit_ff;
   logic [CW-1:0]                len_out_ff;
   logic                         zero_ff;

   // stage inputs; the first stage sees the plain magnitude, which never exceeds the length
   always_comb begin
      len_src[0]  = in_len;
      sign_src[0] = in_sign;
      for (int l = 0; l < LaneCount; l++) begin
         part[0][l]    = {1'b0, in_mag[l]};
         quo_src[0][l] = '0;
      end
      for (int s = 1; s < NQ; s++) begin
         len_src[s]  = len_ff[s-1];
         sign_src[s] = sign_ff[s-1];
         for (int l = 0; l < LaneCount; l++) begin
            part[s][l]    = {rem_ff[s-1][l], 1'b0};
            quo_src[s][l] = quo_ff[s-1][l];
         end
      end
   end

   // one quotient bit per stage and lane, remainder stays below a nonzero length
   always_comb begin
      for (int s = 0; s < NQ; s++) begin
         for (int l = 0; l < LaneCount; l++) begin
            diff[s][l] = part[s][l] - {1'b0, len_src[s]};
            if (part[s][l] >= {1'b0, len_src[s]}) begin
               rem_in[s][l] = diff[s][l][CW-1:0];
               quo_in[s][l] = {quo_src[s][l][NQ-2:0], 1'b1};
            end else begin
               rem_in[s][l] = part[s][l][CW-1:0];
               quo_in[s][l] = {quo_src[s][l][NQ-2:0], 1'b0};
            end
         end
      end
   end

   // final stage: saturate to one, apply sign, force zero for a zero vector
   always_comb begin
      neg_last = {sign_ff[NQ-1].neg_z, sign_ff[NQ-1].neg_y, sign_ff[NQ-1].neg_x};
      zero_in  = (len_ff[NQ-1] == '0);
      for (int l = 0; l < LaneCount; l++) begin
         quo_sat[l]  = (quo_ff[NQ-1][l] > UnitOne) ? UnitOne : quo_ff[NQ-1][l];
         mag_last[l] = UW'(quo_sat[l]);
         if (zero_in) begin
            unit_in[l] = '0;
         end else if (neg_last[l]) begin
            unit_in[l] = ~mag_last[l] + UW'(1);
         end else begin
            unit_in[l] = mag_last[l];
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= {valid_ff[NQ-2:0], in_valid};
         out_valid_ff <= valid_ff[NQ-1];
      end
   end

   // stage and output payload
   always_ff @(posedge clock) begin
      for (int s = 0; s < NQ; s++) begin
         len_ff[s]  <= len_src[s];
         sign_ff[s] <= sign_src[s];
         for (int l = 0; l < LaneCount; l++) begin
            rem_ff[s][l] <= rem_in[s][l];
            quo_ff[s][l] <= quo_in[s][l];
         end
      end
      unit_ff    <= unit_in;
      len_out_ff <= len_ff[NQ-1];
      zero_ff    <= zero_in;
   end

   assign out_valid = out_valid_ff;
   assign out_unit  = unit_ff;
   assign out_len   = len_out_ff;
   assign out_zero  = zero_ff;

endmodule

>>> sv/vector3_normalize_unit.sv
// top level: 3d vector length and unit vector, one vector per clock
//
//   channel   ports                                    timing
//   input     start, busy, req_comp_x/y/z              taken when start and not busy
//   result    rsp_valid, rsp_unit_x/y/z, rsp_length,   one cycle per item, no hold-off
//             rsp_zero_vector
//
// an item enters every clock; busy is always low since nothing stalls the pipeline
// the pipeline has three front-end stages, one square-root stage per length bit,
// one divider stage per quotient bit and one output stage
// reset clears only the valid bits; items in flight are dropped
module vector3_normalize_unit #(
   parameter int COMP_WIDTH     = 16,
   parameter int UNIT_FRAC_BITS = 14
) (
   input  logic                                                     clock,
   input  logic                                                     reset,
   input  logic                                                     start,
   output logic                                                     busy,
   input  logic signed [COMP_WIDTH-1:0]                             req_comp_x,
   input  logic signed [COMP_WIDTH-1:0]                             req_comp_y,
   input  logic signed [COMP_WIDTH-1:0]                             req_comp_z,
   output logic                                                     rsp_valid,
   output logic signed [UNIT_FRAC_BITS+vnorm_pkg::UnitIntBits-1:0]  rsp_unit_x,
   output logic signed [UNIT_FRAC_BITS+vnorm_pkg::UnitIntBits-1:0]  rsp_unit_y,
   output logic signed [UNIT_FRAC_BITS+vnorm_pkg::UnitIntBits-1:0]  rsp_unit_z,
   output logic [COMP_WIDTH-1:0]                                    rsp_length,
   output logic                                                     rsp_zero_vector
);
   import vnorm_pkg::*;

   localparam int CW     = COMP_WIDTH;
   localparam int UW     = UNIT_FRAC_BITS + UnitIntBits;
   localparam int SignW  = $bits(sign_type);
   localparam int SideW  = LaneCount * CW + SignW;

   logic                         sq_valid;
   logic [2*CW-1:0]              sq_sum;
   logic [LaneCount-1:0][CW-1:0] sq_mag;
   sign_type                     sq_sign;
   logic [SideW-1:0]             sq_side;

   logic                         rt_valid;
   logic [CW-1:0]                rt_len;
   logic [SideW-1:0]             rt_side;
   logic [LaneCount-1:0][CW-1:0] rt_mag;
   sign_type                     rt_sign;

   logic [LaneCount-1:0][UW-1:0] dv_unit;

   // the pipeline never stalls
   assign busy = 1'b0;

   // squares and sum of squares
   vnorm_sumsq #(
      .CW (CW)
   ) u_sumsq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .in_comp_x (req_comp_x),
      .in_comp_y (req_comp_y),
      .in_comp_z (req_comp_z),
      .out_valid (sq_valid),
      .out_sum   (sq_sum),
      .out_mag   (sq_mag),
      .out_sign  (sq_sign)
   );

   // magnitudes and signs ride along with the square root
   assign sq_side = {sq_mag, sq_sign};

   vnorm_sqrt #(
      .CW     (CW),
      .SIDE_W (SideW)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_sum    (sq_sum),
      .in_side   (sq_side),
      .out_valid (rt_valid),
      .out_root  (rt_len),
      .out_side  (rt_side)
   );

   assign rt_mag  = rt_side[SideW-1:SignW];
   assign rt_sign = rt_side[SignW-1:0];

   // per-component division by the length
   vnorm_div #(
      .CW (CW),
      .UF (UNIT_FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rt_valid),
      .in_len    (rt_len),
      .in_mag    (rt_mag),
      .in_sign   (rt_sign),
      .out_valid (rsp_valid),
      .out_unit  (dv_unit),
      .out_len   (rsp_length),
      .out_zero  (rsp_zero_vector)
   );

   assign rsp_unit_x = dv_unit[0];
   assign rsp_unit_y = dv_unit[1];
   assign rsp_unit_z = dv_unit[2];

endmodule

>>> bench/vnorm_checker.sv
// checker for the 3d vector normalize unit: predicts each item's length and unit vector
`timescale 1ns / 100ps

module vnorm_checker #(
   parameter int COMP_WIDTH     = 16,
   parameter int UNIT_FRAC_BITS = 14
) (
   input  logic                                                     clock,
   input  logic                                                     reset,
   input  logic                                                     start,
   input  logic                                                     busy,
   input  logic signed [COMP_WIDTH-1:0]                             req_comp_x,
   input  logic signed [COMP_WIDTH-1:0]                             req_comp_y,
   input  logic signed [COMP_WIDTH-1:0]                             req_comp_z,
   input  logic                                                     rsp_valid,
   input  logic signed [UNIT_FRAC_BITS+vnorm_pkg::UnitIntBits-1:0]  rsp_unit_x,
   input  logic signed [UNIT_FRAC_BITS+vnorm_pkg::UnitIntBits-1:0]  rsp_unit_y,
   input  logic signed [UNIT_FRAC_BITS+vnorm_pkg::UnitIntBits-1:0]  rsp_unit_z,
   input  logic [COMP_WIDTH-1:0]                                    rsp_length,
   input  logic                                                     rsp_zero_vector,
   output int                                                       fail_count,
   output int                                                       vectors_in_flight
);

   localparam int UnitWidth = UNIT_FRAC_BITS + vnorm_pkg::UnitIntBits;

   typedef struct {
      logic signed [UnitWidth-1:0] unit_x;
      logic signed [UnitWidth-1:0] unit_y;
      logic signed [UnitWidth-1:0] unit_z;
      logic [COMP_WIDTH-1:0]       length;
      logic                        zero_vector;
   } norm_result_type;

   // expected normalize results, oldest first
   norm_result_type pending_norms[$];

   initial begin
      fail_count        = 0;
      vectors_in_flight = 0;
   end

   // magnitude of a signed component, widened so the most negative value fits
   function automatic longint unsigned comp_magnitude(logic signed [COMP_WIDTH-1:0] comp);
      longint wide;
      wide = comp;
      return (wide < 0) ? longint'(-wide) : longint'(wide);
   endfunction

   // largest root whose square does not exceed the sum, one bit at a time from the top
   function automatic longint unsigned floor_root(longint unsigned sum_sq);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = COMP_WIDTH; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= sum_sq) root = trial;
      end
      return root;
   endfunction

   // one unit component: scaled magnitude over length, truncated, clamped to one, signed
   function automatic logic signed [UnitWidth-1:0] unit_of(longint unsigned mag, logic neg,
                                                           longint unsigned len);
      longint unsigned quot;
      logic signed [UnitWidth-1:0] unit;
      quot = (mag << UNIT_FRAC_BITS) / len;
      if (quot > (64'd1 << UNIT_FRAC_BITS)) quot = 64'd1 << UNIT_FRAC_BITS;
      unit = quot[UnitWidth-1:0];
      return neg ? -unit : unit;
   endfunction

   function automatic norm_result_type predict_norm(logic signed [COMP_WIDTH-1:0] cx,
                                                    logic signed [COMP_WIDTH-1:0] cy,
                                                    logic signed [COMP_WIDTH-1:0] cz);
      norm_result_type res;
      vnorm_pkg::sign_type signs;
      longint unsigned mx, my, mz, sum_sq, len;
      signs.neg_x = cx[COMP_WIDTH-1];
      signs.neg_y = cy[COMP_WIDTH-1];
      signs.neg_z = cz[COMP_WIDTH-1];
      mx = comp_magnitude(cx);
      my = comp_magnitude(cy);
      mz = comp_magnitude(cz);
      sum_sq = mx * mx + my * my + mz * mz;
      // zero vector: flag set, everything else forced to zero
      if (sum_sq == 0) begin
         res.unit_x      = '0;
         res.unit_y      = '0;
         res.unit_z      = '0;
         res.length      = '0;
         res.zero_vector = 1'b1;
         return res;
      end
      len = floor_root(sum_sq);
      res.unit_x      = unit_of(mx, signs.neg_x, len);
      res.unit_y      = unit_of(my, signs.neg_y, len);
      res.unit_z      = unit_of(mz, signs.neg_z, len);
      res.length      = len[COMP_WIDTH-1:0];
      res.zero_vector = 1'b0;
      return res;
   endfunction

   task automatic compare_field(string field, logic signed [31:0] want, logic signed [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         fail_count++;
      end
   endtask

   // watch both channels at each edge
   always @(posedge clock) begin
      norm_result_type want;
      if (!reset) begin
         if (start === 1'b1 && busy === 1'b0)
            pending_norms.push_back(predict_norm(req_comp_x, req_comp_y, req_comp_z));
         if (rsp_valid !== 1'b0) begin
            if (pending_norms.size() == 0) begin
               $error("result strobe with no item outstanding (rsp_valid=%b)", rsp_valid);
               fail_count++;
            end else begin
               want = pending_norms.pop_front();
               compare_field("unit_x", want.unit_x, rsp_unit_x);
               compare_field("unit_y", want.unit_y, rsp_unit_y);
               compare_field("unit_z", want.unit_z, rsp_unit_z);
               compare_field("length", want.length, rsp_length);
               compare_field("zero_vector", want.zero_vector, rsp_zero_vector);
            end
         end
      end
      vectors_in_flight <= pending_norms.size();
   end

endmodule

>>> bench/tb_top.sv
// testbench top for the 3d vector normalize unit: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_top;

   localparam int CompWidth    = 16;
   localparam int UnitFracBits = 14;
   localparam int UnitWidth    = UnitFracBits + vnorm_pkg::UnitIntBits;
   localparam int PipeLatency  = CompWidth + UnitFracBits + 5;
   localparam int RandomItems  = 1500;

   localparam logic signed [CompWidth-1:0] CompMax = {1'b0, {(CompWidth-1){1'b1}}};
   localparam logic signed [CompWidth-1:0] CompMin = {1'b1, {(CompWidth-1){1'b0}}};

   logic                        clock           = 1'b0;
   logic                        reset           = 1'b1;
   logic                        start           = 1'b0;
   logic signed [CompWidth-1:0] req_comp_x      = '0;
   logic signed [CompWidth-1:0] req_comp_y      = '0;
   logic signed [CompWidth-1:0] req_comp_z      = '0;
   logic                        busy;
   logic                        rsp_valid;
   logic signed [UnitWidth-1:0] rsp_unit_x;
   logic signed [UnitWidth-1:0] rsp_unit_y;
   logic signed [UnitWidth-1:0] rsp_unit_z;
   logic [CompWidth-1:0]        rsp_length;
   logic                        rsp_zero_vector;
   int                          fail_count;
   int                          vectors_in_flight;

   always #1 clock = ~clock;

   vector3_normalize_unit #(
      .COMP_WIDTH     (CompWidth),
      .UNIT_FRAC_BITS (UnitFracBits)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_comp_x      (req_comp_x),
      .req_comp_y      (req_comp_y),
      .req_comp_z      (req_comp_z),
      .rsp_valid       (rsp_valid),
      .rsp_unit_x      (rsp_unit_x),
      .rsp_unit_y      (rsp_unit_y),
      .rsp_unit_z      (rsp_unit_z),
      .rsp_length      (rsp_length),
      .rsp_zero_vector (rsp_zero_vector)
   );

   vnorm_checker #(
      .COMP_WIDTH     (CompWidth),
      .UNIT_FRAC_BITS (UnitFracBits)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_comp_x        (req_comp_x),
      .req_comp_y        (req_comp_y),
      .req_comp_z        (req_comp_z),
      .rsp_valid         (rsp_valid),
      .rsp_unit_x        (rsp_unit_x),
      .rsp_unit_y        (rsp_unit_y),
      .rsp_unit_z        (rsp_unit_z),
      .rsp_length        (rsp_length),
      .rsp_zero_vector   (rsp_zero_vector),
      .fail_count        (fail_count),
      .vectors_in_flight (vectors_in_flight)
   );

   // sender burst state
   int burst_left = 0;

   // present one vector and hold it until the unit takes it
   task automatic send_vector(logic signed [CompWidth-1:0] cx, logic signed [CompWidth-1:0] cy,
                              logic signed [CompWidth-1:0] cz);
      start      <= 1'b1;
      req_comp_x <= cx;
      req_comp_y <= cy;
      req_comp_z <= cz;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // random component drawn from one of several value classes
   function automatic logic signed [CompWidth-1:0] pick_comp(int unsigned kind);
      logic signed [CompWidth-1:0] v;
      case (kind)
         0: v = CompWidth'($urandom());
         1: v = CompWidth'($signed($urandom_range(0, 14)) - 7);
         2: case ($urandom_range(0, 4))
               0: v = CompMin;
               1: v = CompMax;
               2: v = -1;
               3: v = 1;
               default: v = 0;
            endcase
         3: v = $urandom_range(0, 1) ? CompWidth'(CompMax - $urandom_range(0, 255))
                                     : CompWidth'(CompMin + $urandom_range(0, 255));
         default: v = 0;
      endcase
      return v;
   endfunction

   // random vector: full range, small, single axis, extremes, near the extremes, or zero or one small axis
   task automatic send_random_vector();
      int unsigned shape;
      int unsigned axis;
      logic signed [CompWidth-1:0] c [3];
      shape = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++) c[i] = '0;
      case (shape)
         0, 1, 2, 3: for (int i = 0; i < 3; i++) c[i] = pick_comp(0);
         4, 5:       for (int i = 0; i < 3; i++) c[i] = pick_comp(1);
         6: begin
            axis    = $urandom_range(0, 2);
            c[axis] = pick_comp($urandom_range(0, 1));
         end
         7:          for (int i = 0; i < 3; i++) c[i] = pick_comp(2);
         8:          for (int i = 0; i < 3; i++) c[i] = pick_comp(3);
         default:    if ($urandom_range(0, 1)) c[$urandom_range(0, 2)] = pick_comp(1);
      endcase
      send_vector(c[0], c[1], c[2]);
   endtask

   // after a burst, unless the gap is zero, drop start, put noise on the component ports and wait a while
   task automatic sender_gap();
      int unsigned gap;
      burst_left--;
      if (burst_left > 0) return;
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap == 0) return;
      start      <= 1'b0;
      req_comp_x <= CompWidth'($urandom());
      req_comp_y <= CompWidth'($urandom());
      req_comp_z <= CompWidth'($urandom());
      repeat (gap) @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero vector, axis extremes, all extremes, mixed signs, small lengths
      send_vector(0, 0, 0);
      send_vector(CompMax, 0, 0);
      send_vector(CompMin, 0, 0);
      send_vector(0, CompMax, 0);
      send_vector(0, CompMin, 0);
      send_vector(0, 0, CompMax);
      send_vector(0, 0, CompMin);
      send_vector(CompMax, CompMax, CompMax);
      send_vector(CompMin, CompMin, CompMin);
      send_vector(CompMax, CompMin, CompMax);
      send_vector(CompMin, CompMax, CompMin);
      send_vector(1, 0, 0);
      send_vector(0, -1, 0);
      send_vector(0, 0, 1);
      send_vector(1, 1, 1);
      send_vector(-1, -1, -1);
      send_vector(1, -1, 0);
      send_vector(2, 1, 0);
      send_vector(3, 1, -1);
      send_vector(3, -3, 0);
      send_vector(2, 2, 2);
      send_vector(0, 0, 0);
      send_vector(-1, CompMax, 1);

      // random part in bursts
      burst_left = $urandom_range(1, 40);
      for (int n = 0; n < RandomItems; n++) begin
         send_random_vector();
         sender_gap();
      end

      // drain the pipeline
      start <= 1'b0;
      @(posedge clock);
      while (vectors_in_flight != 0) @(posedge clock);
      repeat (PipeLatency + 5) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // watchdog
   initial begin
      #200000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
